// ===== src/fmpll_pkg.sv =====
// Package for the FM transmitter PLL tuning sequencer.
// Holds phase codes, frequency constants and the write-list item type.
// No dependencies.
package fmpll_pkg;

  localparam int VOTE_SAMPLES          = 50;
  localparam int SAMPLE_INTERVAL_TICKS = 10;
  localparam int MAX_WR                = 15;

  localparam logic [26:0] F_LOW       = 27'd87500000;
  localparam logic [26:0] F_HIGH      = 27'd108000000;
  localparam logic [26:0] F_OFFSET    = 27'd304000;
  localparam logic [26:0] F_HIGH_BAND = 27'd95000000;
  localparam logic [26:0] F_TOP_BAND  = 27'd104000000;
  localparam logic [26:0] F_FINE      = 27'd100000;
  localparam logic [26:0] F_COARSE    = 27'd1000000;
  localparam logic [26:0] F_OVERLAP   = 27'd2000000;
  localparam logic [7:0]  BAND_BASE   = 8'h18;
  localparam logic [7:0]  MODE_STEREO = 8'hB4;
  localparam logic [7:0]  MODE_MONO   = 8'hFC;
  localparam logic [9:0]  BAND_WAIT   = 10'd499;
  localparam logic [9:0]  PULL_WAIT   = 10'd19;
  localparam logic [9:0]  SETTLE_WAIT = 10'd99;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [2:0] ST_PROG  = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_FAIL  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_BUSY  = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE, PH_COARSE_DLY, PH_COARSE_VOTE, PH_FINE_DLY, PH_FINE_VOTE,
    PH_OVL_DLY, PH_OVL_VOTE, PH_HIGH_WAIT, PH_TOP_WAIT, PH_PULL_WAIT, PH_SETTLE
  } phase_t;

  // one result word
  typedef struct packed {
    logic       wv;
    logic [3:0] addr;
    logic [7:0] data;
    logic [2:0] st;
  } wr_t;

  // a batch of results produced by one item
  typedef struct packed {
    logic [3:0]         cnt;
    wr_t [MAX_WR-1:0]   w;
  } batch_t;

endpackage

// ===== src/fmpll_outq.sv =====
// Output serializer: holds batches of results and plays them out one word at a time.
// Depends on fmpll_pkg.
module fmpll_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fmpll_pkg::batch_t push_b,
  output logic              full,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);
  import fmpll_pkg::*;

  // two batch slots, ping-pong
  batch_t     slot_r [2];
  logic [1:0] used_r, used_nxt;
  logic       rd_r, wr_r;
  logic [3:0] pos_r;
  wr_t        cur;
  logic       pop_word, pop_batch;

  assign cur        = slot_r[rd_r].w[pos_r];
  assign out_tvalid = used_r[rd_r];
  assign out_tlast  = (pos_r == slot_r[rd_r].cnt - 4'd1);
  // fields: reg_addr[4], reg_data[8], status[3], pad
  assign out_tdata  = {1'b0, cur.st, cur.data, cur.addr};
  // fields: write_valid
  assign out_tuser  = cur.wv;
  assign full       = used_r[wr_r];
  assign pop_word   = out_tvalid && out_tready;
  assign pop_batch  = pop_word && out_tlast;

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_b;
  end

  // slot occupancy: fill on push, free on last word
  always_comb begin
    used_nxt = used_r;
    if (push) used_nxt[wr_r] = 1'b1;
    if (pop_batch) used_nxt[rd_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      rd_r   <= 1'b0;
      wr_r   <= 1'b0;
      pos_r  <= '0;
    end else begin
      used_r <= used_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop_batch) begin
        rd_r  <= ~rd_r;
        pos_r <= '0;
      end else if (pop_word) begin
        pos_r <= pos_r + 4'd1;
      end
    end
  end

  // a batch never holds zero words
  assert property (@(posedge clk) disable iff (!rst_n) push |-> push_b.cnt != 4'd0)
    else $error("empty batch pushed");
  // no push into an occupied slot
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full slot");
  // word index stays inside the batch
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> pos_r < slot_r[rd_r].cnt)
    else $error("read past batch end");
endmodule

// ===== src/fm_transmitter_pll_tuning_sequencer.sv =====
// Top level of the FM transmitter PLL tuning sequencer.
// Depends on fmpll_pkg and fmpll_outq.
//
// Usage: in_* carries one item per word: a 1 ms tick with the lock pin
// level, a start command (frequency, stereo, power) or a stop; in_tuser
// holds the operation. Each item produces zero to fifteen result words on
// out_*, one transmitter register write (or status) per word, out_tuser set
// on writes, out_tlast on the last word of the item.
// An accepted item is evaluated combinationally from the state registers
// and its batch of results is registered into a two-slot output buffer.
// Words then drain at one per cycle while out_tready is high. Items that
// produce no result pass straight through at one per cycle while in_tready
// is high. in_tready drops only when both output slots hold unfinished
// batches, i.e. when the receiver stalls the out_* side; an item is never
// lost. Reset (rst_n low, synchronous) returns the sequencer to idle,
// clears the band edge table and its valid flag and empties the buffer.
module fm_transmitter_pll_tuning_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // fields: frequency_hz[27], stereo, power_2mw, lock_pin, pad[2]
  input  logic [31:0] in_tdata,
  // fields: operation[2]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // fields: reg_addr[4], reg_data[8], status[3], pad
  output logic [15:0] out_tdata,
  // fields: write_valid
  output logic        out_tuser,
  output logic        out_tlast
);
  import fmpll_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [26:0] tbl_r [3];
  logic [26:0] tbl_nxt [3];
  logic        tv_r, tv_nxt;
  logic [26:0] sf_r, sf_nxt, tf_r, tf_nxt;
  logic [1:0]  bi_r, bi_nxt, mode_r, mode_nxt;
  logic [5:0]  lv_r, lv_nxt, vs_r, vs_nxt;
  logic [9:0]  wt_r, wt_nxt;
  batch_t      b;
  logic        full, acc, push;

  logic [1:0]  op;
  logic [26:0] freq;
  assign op   = in_tuser;
  assign freq = in_tdata[26:0];
  assign in_tready = !full;
  assign acc  = in_tvalid && in_tready;
  assign push = acc && b.cnt != 4'd0;

  // sequencer combinational step
  always_comb begin
    logic [26:0] pf, d13;
    logic        locked;
    logic [1:0]  kind, cntb;
    logic        dofail, doprobe, doland, doramp, dofinal;
    ph_nxt = ph_r; tbl_nxt = tbl_r; tv_nxt = tv_r; sf_nxt = sf_r; tf_nxt = tf_r;
    bi_nxt = bi_r; mode_nxt = mode_r; lv_nxt = lv_r; vs_nxt = vs_r; wt_nxt = wt_r;
    b = '0;
    pf = '0; d13 = '0; locked = 1'b0; kind = 2'd0; cntb = 2'd0;
    dofail = 1'b0; doprobe = 1'b0; doland = 1'b0; doramp = 1'b0; dofinal = 1'b0;

    unique case (op)
      OP_START: begin
        if (ph_r != PH_IDLE) begin
          b.w[0] = '{1'b0, 4'd0, 8'h00, ST_BUSY}; b.cnt = 4'd1;
        end else if (freq < F_LOW || freq > F_HIGH) begin
          b.w[0] = '{1'b0, 4'd0, 8'h00, ST_RANGE}; b.cnt = 4'd1;
        end else begin
          tf_nxt   = freq + F_OFFSET;
          mode_nxt = {in_tdata[28], in_tdata[27]};
          b.w[0]  = '{1'b1, 4'd14, 8'h05, ST_PROG};
          b.w[1]  = '{1'b1, 4'd1,  8'hB4, ST_PROG};
          b.w[2]  = '{1'b1, 4'd2,  8'h06, ST_PROG};
          b.w[3]  = '{1'b1, 4'd5,  8'h00, ST_PROG};
          b.w[4]  = '{1'b1, 4'd6,  8'h1E, ST_PROG};
          b.w[5]  = '{1'b1, 4'd7,  8'h00, ST_PROG};
          b.w[6]  = '{1'b1, 4'd8,  8'h1A, ST_PROG};
          b.w[7]  = '{1'b1, 4'd9,  8'h00, ST_PROG};
          b.w[8]  = '{1'b1, 4'd10, 8'h00, ST_PROG};
          b.w[9]  = '{1'b1, 4'd11, 8'h00, ST_PROG};
          b.w[10] = '{1'b1, 4'd0,  8'h05, ST_PROG};
          b.w[11] = '{1'b1, 4'd14, 8'h05, ST_PROG};
          b.cnt = 4'd12;
          if (tv_r) doramp = 1'b1;
          else begin
            bi_nxt = 2'd3;
            b.w[12] = '{1'b1, 4'd8, BAND_BASE | 8'd3, ST_PROG};
            b.cnt = 4'd13;
            sf_nxt = F_LOW;
            doprobe = 1'b1; kind = 2'd0;
          end
        end
      end
      OP_STOP: begin
        b.w[0] = '{1'b1, 4'd0, 8'h00, ST_PROG}; b.cnt = 4'd1;
        ph_nxt = PH_IDLE;
      end
      OP_TICK: begin
        if (ph_r == PH_IDLE || ph_r > PH_SETTLE) ph_nxt = PH_IDLE;
        else if (wt_r != 10'd0) wt_nxt = wt_r - 10'd1;
        else begin
          unique case (ph_r)
            PH_COARSE_DLY: begin doland = 1'b1; kind = 2'd0; end
            PH_FINE_DLY:   begin doland = 1'b1; kind = 2'd1; end
            PH_OVL_DLY:    begin doland = 1'b1; kind = 2'd2; end
            PH_COARSE_VOTE, PH_FINE_VOTE, PH_OVL_VOTE: begin
              lv_nxt = lv_r + {5'd0, in_tdata[29]};
              vs_nxt = vs_r + 6'd1;
              wt_nxt = 10'(SAMPLE_INTERVAL_TICKS - 1);
              if (vs_nxt >= 6'(VOTE_SAMPLES)) begin
                locked = {lv_nxt, 1'b0} >= 7'(VOTE_SAMPLES);
                if (ph_r == PH_COARSE_VOTE) begin
                  if (locked) begin
                    sf_nxt = sf_r + F_COARSE; kind = 2'd0;
                  end else begin
                    sf_nxt = sf_r - F_COARSE + F_FINE; kind = 2'd1;
                  end
                  if (sf_nxt > F_HIGH) dofail = 1'b1; else doprobe = 1'b1;
                end else if (ph_r == PH_FINE_VOTE) begin
                  if (locked) begin
                    sf_nxt = sf_r + F_FINE; kind = 2'd1;
                    if (sf_nxt > F_HIGH) dofail = 1'b1; else doprobe = 1'b1;
                  end else begin
                    kind = 2'd2; doprobe = 1'b1;
                  end
                end else if (!locked) dofail = 1'b1;
                else begin
                  tbl_nxt[(bi_r == 2'd3) ? 2'd0 : bi_r] = sf_r - F_COARSE;
                  if (bi_r == 2'd0) begin
                    tv_nxt = 1'b1; doramp = 1'b1;
                  end else begin
                    sf_nxt = sf_r + F_COARSE; kind = 2'd0;
                    if (sf_nxt > F_HIGH) dofail = 1'b1; else doprobe = 1'b1;
                  end
                end
              end
            end
            PH_HIGH_WAIT: begin
              if (tf_r >= F_TOP_BAND) begin
                sf_nxt = F_TOP_BAND;
                d13 = F_TOP_BAND >> 13;
                b.w[0] = '{1'b1, 4'd3, d13[7:0], ST_PROG};
                b.w[1] = '{1'b1, 4'd4, d13[15:8], ST_PROG};
                b.w[2] = '{1'b1, 4'd8, BAND_BASE, ST_PROG};
                b.cnt = 4'd3;
                ph_nxt = PH_TOP_WAIT; wt_nxt = BAND_WAIT;
              end else dofinal = 1'b1;
            end
            PH_TOP_WAIT, PH_PULL_WAIT: begin
              if (sf_r < tf_r) begin
                sf_nxt = sf_r + F_FINE;
                d13 = sf_nxt >> 13;
                b.w[0] = '{1'b1, 4'd3, d13[7:0], ST_PROG};
                b.w[1] = '{1'b1, 4'd4, d13[15:8], ST_PROG};
                b.cnt = 4'd2;
                ph_nxt = PH_PULL_WAIT; wt_nxt = PULL_WAIT;
              end else dofinal = 1'b1;
            end
            default: begin
              b.w[0] = '{1'b1, 4'd6, 8'h1A, ST_PROG};
              b.w[1] = '{1'b1, 4'd1, mode_r[0] ? MODE_STEREO : MODE_MONO, ST_PROG};
              b.w[2] = '{1'b1, 4'd2, mode_r[1] ? 8'h07 : 8'h06, ST_PROG};
              b.w[3] = '{1'b1, 4'd0, 8'h01, ST_OK};
              b.cnt = 4'd4;
              ph_nxt = PH_IDLE;
            end
          endcase
        end
      end
      default: ;
    endcase

    // failure: power off
    if (dofail) begin
      b.w[b.cnt] = '{1'b1, 4'd0, 8'h00, ST_FAIL};
      b.cnt = b.cnt + 4'd1;
      ph_nxt = PH_IDLE;
    end
    // probe the next search point, or land once the parking delay is over
    if (doprobe || doland) begin
      pf = (kind == 2'd2) ? sf_nxt - F_OVERLAP : sf_nxt;
      if (doprobe && pf > F_HIGH_BAND) begin
        d13 = F_HIGH_BAND >> 13;
        b.w[b.cnt] = '{1'b1, 4'd3, d13[7:0], ST_PROG};
        b.w[b.cnt + 4'd1] = '{1'b1, 4'd4, d13[15:8], ST_PROG};
        b.cnt = b.cnt + 4'd2;
        ph_nxt = phase_t'(5'(PH_COARSE_DLY) + {2'b0, kind, 1'b0});
        wt_nxt = '0;
      end else begin
        d13 = pf >> 13;
        b.w[b.cnt] = '{1'b1, 4'd3, d13[7:0], ST_PROG};
        b.w[b.cnt + 4'd1] = '{1'b1, 4'd4, d13[15:8], ST_PROG};
        b.cnt = b.cnt + 4'd2;
        if (kind == 2'd2) begin
          bi_nxt = bi_r - 2'd1;
          b.w[b.cnt] = '{1'b1, 4'd8, BAND_BASE | {6'd0, bi_nxt}, ST_PROG};
          b.cnt = b.cnt + 4'd1;
        end
        ph_nxt = phase_t'(5'(PH_COARSE_VOTE) + {2'b0, kind, 1'b0});
        lv_nxt = '0; vs_nxt = '0; wt_nxt = '0;
      end
    end
    // begin ramp
    if (doramp) begin
      if (tf_nxt >= F_HIGH_BAND) begin
        d13 = F_HIGH_BAND >> 13;
        b.w[b.cnt] = '{1'b1, 4'd3, d13[7:0], ST_PROG};
        b.w[b.cnt + 4'd1] = '{1'b1, 4'd4, d13[15:8], ST_PROG};
        b.w[b.cnt + 4'd2] = '{1'b1, 4'd8, BAND_BASE | 8'd1, ST_PROG};
        b.cnt = b.cnt + 4'd3;
        ph_nxt = PH_HIGH_WAIT; wt_nxt = BAND_WAIT;
      end else dofinal = 1'b1;
    end
    // final frequency and band select
    if (dofinal) begin
      d13 = tf_nxt >> 13;
      cntb = 2'd0;
      if (tf_nxt < tbl_nxt[0]) begin
        cntb = 2'd1;
        if (tf_nxt < tbl_nxt[1]) begin
          cntb = 2'd2;
          if (tf_nxt < tbl_nxt[2]) cntb = 2'd3;
        end
      end
      b.w[b.cnt] = '{1'b1, 4'd3, d13[7:0], ST_PROG};
      b.w[b.cnt + 4'd1] = '{1'b1, 4'd4, d13[15:8], ST_PROG};
      b.w[b.cnt + 4'd2] = '{1'b1, 4'd8, BAND_BASE | {6'd0, cntb}, ST_PROG};
      b.cnt = b.cnt + 4'd3;
      ph_nxt = PH_SETTLE; wt_nxt = SETTLE_WAIT;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; tv_r <= 1'b0; sf_r <= '0; tf_r <= '0; bi_r <= '0;
      mode_r <= '0; lv_r <= '0; vs_r <= '0; wt_r <= '0;
      tbl_r[0] <= '0; tbl_r[1] <= '0; tbl_r[2] <= '0;
    end else if (acc) begin
      ph_r <= ph_nxt; tv_r <= tv_nxt; sf_r <= sf_nxt; tf_r <= tf_nxt; bi_r <= bi_nxt;
      mode_r <= mode_nxt; lv_r <= lv_nxt; vs_r <= vs_nxt; wt_r <= wt_nxt;
      tbl_r <= tbl_nxt;
    end
  end

  fmpll_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push(push), .push_b(b), .full(full),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // a batch never exceeds fifteen words
  assert property (@(posedge clk) disable iff (!rst_n) acc |-> b.cnt <= 4'd15)
    else $error("batch overflow");
  // table marked valid only after a completed calibration
  assert property (@(posedge clk) disable iff (!rst_n) $rose(tv_r) |-> ph_r != PH_IDLE)
    else $error("table valid without ramp");
  // stop always returns to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    acc && op == OP_STOP |=> ph_r == PH_IDLE)
    else $error("stop did not idle");
endmodule

// ===== tb/sv/fmpll_checker.sv =====
// Scoreboard for the FM transmitter PLL tuning sequencer: watches both streams,
// predicts the result words of every accepted item and compares them.
// Depends on fmpll_pkg.
module fmpll_checker
  import fmpll_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // transmitter register numbers
  localparam logic [3:0] REG_CTRL   = 4'd0;
  localparam logic [3:0] REG_MODE   = 4'd1;
  localparam logic [3:0] REG_PWR    = 4'd2;
  localparam logic [3:0] REG_PLL_LO = 4'd3;
  localparam logic [3:0] REG_PLL_HI = 4'd4;
  localparam logic [3:0] REG_R5     = 4'd5;
  localparam logic [3:0] REG_R6     = 4'd6;
  localparam logic [3:0] REG_R7     = 4'd7;
  localparam logic [3:0] REG_BAND   = 4'd8;
  localparam logic [3:0] REG_R9     = 4'd9;
  localparam logic [3:0] REG_R10    = 4'd10;
  localparam logic [3:0] REG_R11    = 4'd11;
  localparam logic [3:0] REG_SRST   = 4'd14;

  typedef enum logic [1:0] {K_COARSE, K_FINE, K_OVL} probe_kind_t;

  typedef struct {
    wr_t  w;
    logic last;
  } word_exp_t;

  // sequencer model state
  phase_t      ph;
  logic [26:0] band_edge [3];
  logic        edges_ok;
  logic [26:0] srch_f;
  logic [26:0] tgt_f;
  logic [1:0]  band_ix;
  logic [5:0]  votes;
  logic [5:0]  samples;
  logic [9:0]  wait_cnt;
  logic [1:0]  mode_bits;

  wr_t       batch[$];
  word_exp_t exp_words[$];

  function void model_reset();
    ph = PH_IDLE;
    foreach (band_edge[i]) band_edge[i] = '0;
    edges_ok  = 1'b0;
    srch_f    = '0;
    tgt_f     = '0;
    band_ix   = '0;
    votes     = '0;
    samples   = '0;
    wait_cnt  = '0;
    mode_bits = '0;
  endfunction

  function void emit(logic wv, logic [3:0] a, logic [7:0] d, logic [2:0] s);
    wr_t w;
    w.wv = wv; w.addr = a; w.data = d; w.st = s;
    if (batch.size() < MAX_WR) batch.push_back(w);
  endfunction

  function void wr(logic [3:0] a, logic [7:0] d);
    emit(1'b1, a, d, ST_PROG);
  endfunction

  function void wr_freq(logic [26:0] f);
    logic [13:0] div;
    div = f[26:13];
    wr(REG_PLL_LO, div[7:0]);
    wr(REG_PLL_HI, {2'b00, div[13:8]});
  endfunction

  function void cal_fail();
    emit(1'b1, REG_CTRL, 8'h00, ST_FAIL);
    ph = PH_IDLE;
  endfunction

  function logic [26:0] probe_f(probe_kind_t k);
    return (k == K_OVL) ? srch_f - F_OVERLAP : srch_f;
  endfunction

  function void land(probe_kind_t k);
    wr_freq(probe_f(k));
    if (k == K_OVL) begin
      band_ix = band_ix - 2'd1;
      wr(REG_BAND, BAND_BASE | {6'd0, band_ix});
    end
    case (k)
      K_COARSE: ph = PH_COARSE_VOTE;
      K_FINE:   ph = PH_FINE_VOTE;
      default:  ph = PH_OVL_VOTE;
    endcase
    votes = '0;
    samples = '0;
    wait_cnt = '0;
  endfunction

  // high probes first park the PLL at the band boundary
  function void probe(probe_kind_t k);
    if (probe_f(k) > F_HIGH_BAND) begin
      wr_freq(F_HIGH_BAND);
      case (k)
        K_COARSE: ph = PH_COARSE_DLY;
        K_FINE:   ph = PH_FINE_DLY;
        default:  ph = PH_OVL_DLY;
      endcase
      wait_cnt = '0;
    end else begin
      land(k);
    end
  endfunction

  function logic step_up(logic [26:0] delta);
    srch_f = srch_f + delta;
    return srch_f <= F_HIGH;
  endfunction

  function void final_set();
    int i;
    i = 0;
    wr_freq(tgt_f);
    while (i < 3 && tgt_f < band_edge[i]) i++;
    wr(REG_BAND, BAND_BASE | 8'(i));
    ph = PH_SETTLE;
    wait_cnt = SETTLE_WAIT;
  endfunction

  function void begin_ramp();
    if (tgt_f >= F_HIGH_BAND) begin
      wr_freq(F_HIGH_BAND);
      wr(REG_BAND, BAND_BASE | 8'd1);
      ph = PH_HIGH_WAIT;
      wait_cnt = BAND_WAIT;
    end else begin
      final_set();
    end
  endfunction

  function void pull_step();
    if (srch_f < tgt_f) begin
      srch_f = srch_f + F_FINE;
      wr_freq(srch_f);
      ph = PH_PULL_WAIT;
      wait_cnt = PULL_WAIT;
    end else begin
      final_set();
    end
  endfunction

  function void vote_done(logic locked);
    if (ph == PH_COARSE_VOTE) begin
      if (locked) begin
        if (!step_up(F_COARSE)) begin cal_fail(); return; end
        probe(K_COARSE);
      end else begin
        srch_f = srch_f - F_COARSE;
        if (!step_up(F_FINE)) begin cal_fail(); return; end
        probe(K_FINE);
      end
    end else if (ph == PH_FINE_VOTE) begin
      if (locked) begin
        if (!step_up(F_FINE)) begin cal_fail(); return; end
        probe(K_FINE);
      end else begin
        probe(K_OVL);
      end
    end else begin
      if (!locked) begin cal_fail(); return; end
      band_edge[band_ix % 3] = srch_f - F_COARSE;
      if (band_ix == 2'd0) begin
        edges_ok = 1'b1;
        begin_ramp();
        return;
      end
      if (!step_up(F_COARSE)) begin cal_fail(); return; end
      probe(K_COARSE);
    end
  endfunction

  function void on_tick(logic pin);
    if (ph == PH_IDLE || ph > PH_SETTLE) begin ph = PH_IDLE; return; end
    if (wait_cnt != 0) begin wait_cnt--; return; end
    case (ph)
      PH_COARSE_DLY: land(K_COARSE);
      PH_FINE_DLY:   land(K_FINE);
      PH_OVL_DLY:    land(K_OVL);
      PH_COARSE_VOTE, PH_FINE_VOTE, PH_OVL_VOTE: begin
        votes = votes + {5'd0, pin};
        samples = samples + 6'd1;
        wait_cnt = 10'(SAMPLE_INTERVAL_TICKS - 1);
        if (samples >= VOTE_SAMPLES) vote_done(2 * int'(votes) >= VOTE_SAMPLES);
      end
      PH_HIGH_WAIT: begin
        if (tgt_f >= F_TOP_BAND) begin
          srch_f = F_TOP_BAND;
          wr_freq(srch_f);
          wr(REG_BAND, BAND_BASE);
          ph = PH_TOP_WAIT;
          wait_cnt = BAND_WAIT;
        end else begin
          final_set();
        end
      end
      PH_TOP_WAIT, PH_PULL_WAIT: pull_step();
      default: begin
        // settle done: restore mode and power, unmute
        wr(REG_R6, 8'h1A);
        wr(REG_MODE, mode_bits[0] ? MODE_STEREO : MODE_MONO);
        wr(REG_PWR, mode_bits[1] ? 8'h07 : 8'h06);
        emit(1'b1, REG_CTRL, 8'h01, ST_OK);
        ph = PH_IDLE;
      end
    endcase
  endfunction

  function void on_start(logic [26:0] f, logic st, logic pw);
    if (ph != PH_IDLE) begin emit(1'b0, '0, '0, ST_BUSY); return; end
    if (f < F_LOW || f > F_HIGH) begin emit(1'b0, '0, '0, ST_RANGE); return; end
    tgt_f = f + F_OFFSET;
    mode_bits = {pw, st};
    wr(REG_SRST, 8'h05);
    wr(REG_MODE, 8'hB4);
    wr(REG_PWR, 8'h06);
    wr(REG_R5, 8'h00);
    wr(REG_R6, 8'h1E);
    wr(REG_R7, 8'h00);
    wr(REG_BAND, 8'h1A);
    wr(REG_R9, 8'h00);
    wr(REG_R10, 8'h00);
    wr(REG_R11, 8'h00);
    wr(REG_CTRL, 8'h05);
    wr(REG_SRST, 8'h05);
    if (edges_ok) begin
      begin_ramp();
    end else begin
      band_ix = 2'd3;
      wr(REG_BAND, BAND_BASE | {6'd0, band_ix});
      srch_f = F_LOW;
      probe(K_COARSE);
    end
  endfunction

  // run one command through the model and queue its words
  function void predict_cmd(logic [1:0] u, logic [31:0] d);
    word_exp_t e;
    batch.delete();
    case (u)
      OP_TICK:  on_tick(d[29]);
      OP_START: on_start(d[26:0], d[27], d[28]);
      OP_STOP: begin
        wr(REG_CTRL, 8'h00);
        ph = PH_IDLE;
      end
      default: ;
    endcase
    foreach (batch[i]) begin
      e.w = batch[i];
      e.last = (i == batch.size() - 1);
      exp_words.push_back(e);
    end
  endfunction

  function void cmp(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    model_reset();
  end

  always @(posedge clk) begin
    word_exp_t e;
    if (!rst_n) begin
      model_reset();
      exp_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (exp_words.size() == 0) begin
          $error("unexpected output word %h", out_tdata);
          fail_count++;
        end else begin
          e = exp_words.pop_front();
          cmp("write_valid", e.w.wv, out_tuser);
          cmp("reg_addr", e.w.addr, out_tdata[3:0]);
          cmp("reg_data", e.w.data, out_tdata[11:4]);
          cmp("status", e.w.st, out_tdata[14:12]);
          cmp("last", e.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready) predict_cmd(in_tuser, in_tdata);
    end
    pending <= exp_words.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the FM transmitter PLL tuning sequencer: clock, reset,
// command stimulus with bursty sender and stalling receiver, watchdog, verdict.
// Depends on fmpll_pkg, fmpll_checker and the sequencer RTL.
module tb;
  import fmpll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  logic        hold_req = 1'b0;
  int          hold_state = 0;
  int          burst_left = 0;
  int          pin_mode = 0;
  int          tick_no = 0;
  int          idle_cycles = 0;

  fm_transmitter_pll_tuning_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  fmpll_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // offer one word, with bursts separated by random gaps
  task automatic send(logic [1:0] op, logic [26:0] f, logic st, logic pw, logic pin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, pin, pw, st, f};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic start_cmd(logic [26:0] f, logic st, logic pw);
    send(OP_START, f, st, pw, 1'($urandom));
  endtask

  task automatic stop_cmd();
    send(OP_STOP, 27'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic ticks_fixed(int n, logic pin);
    repeat (n) send(OP_TICK, 27'($urandom), 1'($urandom), 1'($urandom), pin);
  endtask

  // ticks whose pin pattern changes roughly once per lock vote
  task automatic ticks_mixed(int n);
    logic pin;
    repeat (n) begin
      if (tick_no % 500 == 0) pin_mode = $urandom_range(0, 2);
      tick_no++;
      pin = (pin_mode == 2) ? 1'($urandom) : (pin_mode == 1);
      if ($urandom_range(0, 1999) == 0) begin
        start_cmd(27'($urandom_range(F_LOW, F_HIGH)), 1'($urandom), 1'($urandom));
      end else if ($urandom_range(0, 29999) == 0) begin
        stop_cmd();
      end
      send(OP_TICK, 27'($urandom), 1'($urandom), 1'($urandom), pin);
    end
  endtask

  // receiver: stall pattern by stretches, plus one long hold-off on request
  initial begin
    int rmode;
    @(posedge clk);
    forever begin
      if (hold_req && hold_state == 0) begin
        out_tready <= 1'b0;
        hold_state <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_state <= 2;
      end else begin
        rmode = $urandom_range(0, 2);
        repeat ($urandom_range(10, 60)) begin
          case (rmode)
            0: out_tready <= 1'b1;
            1: out_tready <= ($urandom_range(0, 3) != 0);
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // watchdog on accept activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("fm_transmitter_pll_tuning_sequencer verification failed");
        $finish;
      end
    end
  end

  initial begin
    int r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle behavior and range rejection at the field extremes
    send(OP_TICK, 27'h7FFFFFF, 1'b1, 1'b1, 1'b1);
    stop_cmd();
    send(2'd3, 27'h7FFFFFF, 1'b1, 1'b1, 1'b1);
    start_cmd(27'd0, 1'b0, 1'b0);
    start_cmd(27'h7FFFFFF, 1'b1, 1'b1);
    start_cmd(F_LOW - 27'd1, 1'b0, 1'b1);
    start_cmd(F_HIGH + 27'd1, 1'b1, 1'b0);

    // long receiver hold-off while starts and stops keep coming
    in_tvalid <= 1'b0;
    hold_req <= 1'b1;
    wait (hold_state == 1);
    start_cmd(F_LOW, 1'b0, 1'b0);
    start_cmd(F_HIGH, 1'b1, 1'b1);
    stop_cmd();
    start_cmd(F_HIGH, 1'b1, 1'b1);
    start_cmd(F_LOW, 1'b0, 1'b0);

    // ticks into the first lock vote, then stop it midway
    ticks_fixed(20, 1'b0);
    stop_cmd();
    start_cmd(F_LOW, 1'b1, 1'b0);
    ticks_fixed(12, 1'b1);
    stop_cmd();

    // random command sequences
    for (int s = 0; s < 33; s++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        start_cmd(27'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 9) begin
        start_cmd($urandom_range(0, 1) ? F_LOW - 27'($urandom_range(1, 5))
                                       : F_HIGH + 27'($urandom_range(1, 5)),
                  1'($urandom), 1'($urandom));
      end else if (r < 12) begin
        stop_cmd();
      end else if (r < 14) begin
        send(2'd3, 27'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        start_cmd(27'($urandom_range(F_LOW, F_HIGH)), 1'($urandom), 1'($urandom));
        ticks_mixed($urandom_range(1, 6));
      end
    end

    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("fm_transmitter_pll_tuning_sequencer verification clean");
    end else begin
      $display("fm_transmitter_pll_tuning_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== fm_transmitter_pll_tuning_sequencer.f =====
src/fmpll_pkg.sv
src/fmpll_outq.sv
src/fm_transmitter_pll_tuning_sequencer.sv
tb/sv/fmpll_checker.sv
tb/sv/tb.sv
